FILE: sv/itoa_pkg.sv
`timescale 1ns / 1ps
// itoa_pkg: shared types, constants and glyph lookup for the integer to ascii block
// no dependencies

package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int IN_VALUE_W  = 32;
   localparam int NUM_DIGITS  = VALUE_WIDTH;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
   localparam int COUNT_W     = $clog2(NUM_DIGITS + 1);
   localparam int LEN_W       = 6;

   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_HEX  = 3'd2;
   localparam logic [2:0] MODE_OCT  = 3'd3;
   localparam logic [2:0] MODE_BIN  = 3'd4;

   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LETTER = 8'h57;
   localparam logic [3:0] DEC_LIMIT   = 4'd5;
   localparam logic [3:0] DEC_ADJUST  = 4'd3;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef struct packed {
      logic [IN_VALUE_W-1:0] value;
      logic [2:0]            mode;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]       character;
      logic [LEN_W-1:0] total_length;
      logic             last;
   } rsp_payload_type;

   typedef struct packed {
      logic      clear;
      logic      shift;
      logic      bit_in;
      radix_type radix;
   } chain_ctl_type;

   function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
      logic [7:0] wide;
      wide = {4'b0000, digit};
      if (digit < 4'd10) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_LETTER + wide;
   endfunction

   function automatic radix_type radix_of(input logic [2:0] mode);
      radix_type r;
      unique case (mode)
         MODE_HEX: r = RADIX_HEX;
         MODE_OCT: r = RADIX_OCT;
         MODE_BIN: r = RADIX_BIN;
         default:  r = RADIX_DEC;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// integer_to_ascii_radix: converts a 32-bit value to ascii characters, msb digit first
// steps: accept, bit-serial conversion of all VALUE_WIDTH (32) value bits, one sizing state,
// then one character per cycle from the output register unless rsp_ready stalls it
// a new item is accepted only in idle, once the last character of the previous one is loaded
// reset: synchronous active high, returns to idle and drops rsp_valid
// depends on itoa_pkg and itoa_digit_chain

module integer_to_ascii_radix import itoa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIZE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   radix_type              radix_ff, radix_in;
   logic [COUNT_W-1:0]     conv_cnt_ff, conv_cnt_in;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   load;
   logic                   neg_now;
   logic [VALUE_WIDTH-1:0] raw;
   chain_ctl_type          ctl;
   logic [3:0]             rd_digit;
   logic [COUNT_W-1:0]     digit_count;
   logic [COUNT_W-1:0]     rd_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign raw       = req_data.value[VALUE_WIDTH-1:0];
   assign neg_now   = (req_data.mode == MODE_SDEC) && raw[VALUE_WIDTH-1];
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rd_pos    = rem_ff - COUNT_W'(1);

   always_comb begin
      ctl.clear  = req_fire;
      ctl.shift  = (state_ff == ST_CONV);
      ctl.bit_in = mag_ff[VALUE_WIDTH-1];
      ctl.radix  = radix_ff;
   end

   itoa_digit_chain u_chain (
      .clock       (clock),
      .ctl         (ctl),
      .rd_idx      (rd_pos[DIGIT_IDX_W-1:0]),
      .rd_digit    (rd_digit),
      .digit_count (digit_count)
   );

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      radix_in     = radix_ff;
      conv_cnt_in  = conv_cnt_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mag_in      = neg_now ? (~raw + VALUE_WIDTH'(1)) : raw;
               neg_in      = neg_now;
               radix_in    = radix_of(req_data.mode);
               conv_cnt_in = COUNT_W'(VALUE_WIDTH);
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in      = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff - COUNT_W'(1);
            if (conv_cnt_ff == COUNT_W'(1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            rem_in   = digit_count;
            len_in   = LEN_W'(digit_count) + LEN_W'(neg_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.total_length = len_ff;
               if (neg_ff) begin
                  rsp_data_in.character = CHAR_MINUS;
                  rsp_data_in.last      = 1'b0;
                  neg_in                = 1'b0;
               end else begin
                  rsp_data_in.character = digit_glyph(rd_digit);
                  rsp_data_in.last      = (rem_ff == COUNT_W'(1));
                  rem_in                = rd_pos;
                  if (rem_ff == COUNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      radix_ff    <= radix_in;
      conv_cnt_ff <= conv_cnt_in;
      rem_ff      <= rem_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // digits left to emit while emitting
   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != '0))
      else $error("emit state with no digit left");

   // final character closes the item
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_data_in.last) |=> (state_ff == ST_IDLE))
      else $error("last character did not end the item");

   // shown length stays in range
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.total_length != '0 &&
                        rsp_data_ff.total_length <= LEN_W'(VALUE_WIDTH + 1)))
      else $error("total length out of range");

   // conversion runs the full bit count before sizing
   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIZE) |-> ($past(conv_cnt_ff) == COUNT_W'(1)))
      else $error("sizing entered before conversion finished");

endmodule

FILE: sv/itoa_digit_chain.sv
`timescale 1ns / 1ps
// itoa_digit_chain: digit shift chain, one value bit enters per cycle while ctl.shift is set, msb first
// decimal digits get the add-3 correction, power-of-two radices shift plainly
// depends on itoa_pkg

module itoa_digit_chain import itoa_pkg::*; (
   input  logic                   clock,
   input  chain_ctl_type          ctl,
   input  logic [DIGIT_IDX_W-1:0] rd_idx,
   output logic [3:0]             rd_digit,
   output logic [COUNT_W-1:0]     digit_count
);

   logic [3:0]         digit_ff [NUM_DIGITS];
   logic [3:0]         digit_in [NUM_DIGITS];
   logic [3:0]         adj      [NUM_DIGITS];
   logic               cout     [NUM_DIGITS];
   logic               cin      [NUM_DIGITS];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [3:0]         top_new;
   logic               grow;

   // carry out of each digit depends on that digit alone
   always_comb begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
         if (ctl.radix == RADIX_DEC && digit_ff[j] >= DEC_LIMIT) begin
            adj[j] = digit_ff[j] + DEC_ADJUST;
         end else begin
            adj[j] = digit_ff[j];
         end
         unique case (ctl.radix)
            RADIX_DEC: cout[j] = adj[j][3];
            RADIX_HEX: cout[j] = adj[j][3];
            RADIX_OCT: cout[j] = adj[j][2];
            RADIX_BIN: cout[j] = adj[j][0];
            default:   cout[j] = adj[j][3];
         endcase
      end
      cin[0] = ctl.bit_in;
      for (int j = 1; j < NUM_DIGITS; j++) begin
         cin[j] = cout[j-1];
      end
      for (int j = 0; j < NUM_DIGITS; j++) begin
         unique case (ctl.radix)
            RADIX_DEC: digit_in[j] = {adj[j][2:0], cin[j]};
            RADIX_HEX: digit_in[j] = {adj[j][2:0], cin[j]};
            RADIX_OCT: digit_in[j] = {1'b0, adj[j][1:0], cin[j]};
            RADIX_BIN: digit_in[j] = {3'b000, cin[j]};
            default:   digit_in[j] = {adj[j][2:0], cin[j]};
         endcase
      end
   end

   // the value at most doubles per step, so at most one new digit appears
   always_comb begin
      top_new  = digit_in[count_ff[DIGIT_IDX_W-1:0]];
      grow     = (count_ff < COUNT_W'(NUM_DIGITS)) && (top_new != 4'd0);
      count_in = count_ff + COUNT_W'(grow);
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int j = 0; j < NUM_DIGITS; j++) begin
            digit_ff[j] <= 4'd0;
         end
         count_ff <= COUNT_W'(1);
      end else if (ctl.shift) begin
         digit_ff <= digit_in;
         count_ff <= count_in;
      end
   end

   assign rd_digit    = digit_ff[rd_idx];
   assign digit_count = count_ff;

endmodule

FILE: bench/tb_integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// tb_integer_to_ascii_radix: self-checking bench for the integer to ascii converter,
// directed table then random items under mixed handshake idling, results checked per char
// depends on itoa_pkg and integer_to_ascii_radix

module tb_integer_to_ascii_radix;
   import itoa_pkg::*;

   localparam logic [2:0] MODE_SPARE_5 = 3'd5;
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   localparam int DIRECTED_ROWS  = 25;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 70;
   localparam int HOLD_CYCLES    = 300;

   typedef byte unsigned char_list_type[$];

   typedef struct {
      logic [31:0] value;
      logic [2:0]  mode;
      string       text;
   } directed_row_type;

   // empty text means the row is checked against spell_number
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'h0000_0000, MODE_SDEC,    "0"},
      '{32'h0000_0000, MODE_UDEC,    "0"},
      '{32'h0000_0000, MODE_HEX,     "0"},
      '{32'h0000_0000, MODE_OCT,     "0"},
      '{32'h0000_0000, MODE_BIN,     "0"},
      '{32'h0000_0001, MODE_SDEC,    "1"},
      '{32'hffff_ffff, MODE_SDEC,    "-1"},
      '{32'h8000_0000, MODE_SDEC,    "-2147483648"},
      '{32'h7fff_ffff, MODE_SDEC,    "2147483647"},
      '{32'hffff_fff6, MODE_SDEC,    "-10"},
      '{32'hffff_ffff, MODE_UDEC,    "4294967295"},
      '{32'h8000_0000, MODE_UDEC,    "2147483648"},
      '{32'h0000_000a, MODE_UDEC,    "10"},
      '{32'hffff_ffff, MODE_HEX,     "ffffffff"},
      '{32'hdead_beef, MODE_HEX,     "deadbeef"},
      '{32'h0abc_def0, MODE_HEX,     "abcdef0"},
      '{32'hffff_ffff, MODE_OCT,     "37777777777"},
      '{32'h0000_0008, MODE_OCT,     "10"},
      '{32'hffff_ffff, MODE_BIN,     "11111111111111111111111111111111"},
      '{32'h0000_0005, MODE_BIN,     "101"},
      '{32'h8000_0000, MODE_BIN,     ""},
      '{32'h1234_5678, MODE_SDEC,    ""},
      '{32'h0000_007b, MODE_SPARE_5, "123"},
      '{32'hffff_ffff, MODE_SPARE_6, "4294967295"},
      '{32'h0000_0000, MODE_SPARE_7, "0"}
   };

   int idle_mix  [4] = '{0, 73, 0, 23};
   int stall_mix [4] = '{0, 0, 73, 23};
   int phase_len [4] = '{90, 85, 85, 85};

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   rsp_payload_type expected_chars[$];
   rsp_payload_type wanted_char;
   int              error_count;
   int              chars_checked;
   int              items_sent;
   int              quiet_cycles;
   int              sender_idle_pct;
   int              receiver_stall_pct;
   int              hold_left;
   logic            hold_request;

   integer_to_ascii_radix dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // characters of one conversion, minus sign then digits, most significant first
   function automatic char_list_type spell_number(input req_payload_type item);
      char_list_type text;
      string         glyphs;
      logic [31:0]   magnitude;
      logic [31:0]   base;
      logic          negative;
      glyphs = "0123456789abcdef";
      case (item.mode)
         MODE_HEX: base = 32'd16;
         MODE_OCT: base = 32'd8;
         MODE_BIN: base = 32'd2;
         default:  base = 32'd10;
      endcase
      negative  = (item.mode == MODE_SDEC) && item.value[31];
      magnitude = negative ? (~item.value + 32'd1) : item.value;
      do begin
         text.push_front(glyphs[magnitude % base]);
         magnitude = magnitude / base;
      end while (magnitude != 32'd0);
      if (negative) begin
         text.push_front(CHAR_MINUS);
      end
      return text;
   endfunction

   function automatic void expect_chars(input char_list_type text);
      rsp_payload_type one_char;
      for (int k = 0; k < text.size(); k++) begin
         one_char.character    = text[k];
         one_char.total_length = LEN_W'(text.size());
         one_char.last         = (k == text.size() - 1);
         expected_chars.push_back(one_char);
      end
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 6))
         0:       return 32'($urandom_range(0, 20));
         1:       return 32'h1 << $urandom_range(0, 31);
         2:       return 32'hffff_ffff - $urandom_range(0, 20);
         3:       return 32'h8000_0000 | $urandom_range(0, 3);
         4:       return 32'h7fff_ffff - $urandom_range(0, 3);
         5:       return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_payload_type item, input string typed_text);
      char_list_type text;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (typed_text.len() > 0) begin
         for (int k = 0; k < typed_text.len(); k++) begin
            text.push_back(typed_text[k]);
         end
      end else begin
         text = spell_number(item);
      end
      expect_chars(text);
      items_sent++;
   endtask

   // receiver side
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            $display("%0t unexpected char: got char %h len %0d last %b", $time,
                     rsp_data.character, rsp_data.total_length, rsp_data.last);
         end else begin
            wanted_char = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data !== wanted_char) begin
               error_count++;
               $display("%0t mismatch: expected %h len %0d last %b, got %h len %0d last %b",
                        $time, wanted_char.character, wanted_char.total_length, wanted_char.last,
                        rsp_data.character, rsp_data.total_length, rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req_payload_type item;
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      rsp_ready          = 1'b0;
      hold_request       = 1'b0;
      hold_left          = 0;
      error_count        = 0;
      chars_checked      = 0;
      items_sent         = 0;
      quiet_cycles       = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         item.value = directed_rows[r].value;
         item.mode  = directed_rows[r].mode;
         send_item(item, directed_rows[r].text);
      end

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = idle_mix[p];
         receiver_stall_pct = stall_mix[p];
         for (int i = 0; i < phase_len[p]; i++) begin
            if (p == 0 && i == 30) begin
               hold_request = 1'b1;
            end
            if (p == 1 && i == 45) begin
               req_valid <= 1'b0;
               wait (expected_chars.size() == 0);
            end
            item.value = pick_value();
            if ($urandom_range(0, 9) == 0) begin
               item.mode = 3'($urandom_range(5, 7));
            end else begin
               item.mode = 3'($urandom_range(0, 4));
            end
            send_item(item, "");
         end
      end
      req_valid <= 1'b0;

      wait (expected_chars.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         error_count++;
         $display("%0t %0d chars never arrived", $time, expected_chars.size());
      end
      $display("converted %0d values in all five modes plus spare codes, %0d chars compared",
               items_sent, chars_checked);
      $display("handshake mixes: free flow, sender gaps, receiver stalls, both, long hold-off");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/itoa_pkg.sv
sv/itoa_digit_chain.sv
sv/integer_to_ascii_radix.sv
bench/tb_integer_to_ascii_radix.sv
